/* hdl/audio_reactive_led_level_assert.svh */
// Assertion helpers for the LED level block.
// Both sample on the rising clock edge and are off while reset is high.
`ifndef AUDIO_REACTIVE_LED_LEVEL_ASSERT_SVH
`define AUDIO_REACTIVE_LED_LEVEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARLL_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ARLL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* hdl/arll_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package arll_pkg;

   // Register indexes on the csr port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_DC_SHIFT     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BASS_SHIFT   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_TREBLE_RISE  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_TREBLE_FALL  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_BASS_RISE    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_BASS_FALL    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_TREBLE_FLOOR = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_BASS_FLOOR   = 3'd7;

   // Register reset values
   localparam logic [3:0]  DC_SHIFT_RST     = 4'd5;
   localparam logic [3:0]  BASS_SHIFT_RST   = 4'd3;
   localparam logic [15:0] TREBLE_RISE_RST  = 16'(65535 / 30);
   localparam logic [15:0] TREBLE_FALL_RST  = 16'(65535 / 300);
   localparam logic [15:0] BASS_RISE_RST    = 16'(65535 / 40);
   localparam logic [15:0] BASS_FALL_RST    = 16'(65535 / 700);
   localparam logic [14:0] TREBLE_FLOOR_RST = 15'd70;
   localparam logic [14:0] BASS_FLOOR_RST   = 15'd40;

   // Threshold adaptation
   localparam int unsigned        ADAPT_PERIOD_DEF = 64;
   localparam logic [15:0]        ENERGY_LIMIT     = 16'd4096;
   localparam logic signed [15:0] THRESH_CEIL      = 16'sd32000;

   // Per-channel ramp and threshold settings
   typedef struct packed {
      logic [15:0] rise;
      logic [15:0] fall;
      logic [14:0] floor_v;
   } arll_chan_cfg_type;

   localparam logic [7:0] EXP_TABLE [256] = '{
      8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
      8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
      8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,
      8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,
      8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd5,8'd6,
      8'd6,8'd6,8'd6,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,
      8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd9,8'd9,8'd10,8'd10,8'd10,8'd10,8'd10,8'd11,8'd11,
      8'd11,8'd11,8'd12,8'd12,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd14,8'd14,
      8'd15,8'd15,8'd15,8'd16,8'd16,8'd16,8'd17,8'd17,8'd18,8'd18,8'd18,8'd19,8'd19,
      8'd20,8'd20,8'd21,8'd21,8'd21,8'd22,8'd22,8'd23,8'd23,8'd24,8'd24,8'd25,8'd25,
      8'd26,8'd27,8'd27,8'd28,8'd28,8'd29,8'd30,8'd30,8'd31,8'd32,8'd32,8'd33,8'd34,
      8'd35,8'd35,8'd36,8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,8'd43,8'd44,8'd45,
      8'd46,8'd47,8'd48,8'd49,8'd50,8'd51,8'd52,8'd53,8'd55,8'd56,8'd57,8'd58,8'd59,
      8'd61,8'd62,8'd63,8'd65,8'd66,8'd68,8'd69,8'd71,8'd72,8'd74,8'd76,8'd77,8'd79,
      8'd81,8'd82,8'd84,8'd86,8'd88,8'd90,8'd92,8'd94,8'd96,8'd98,8'd100,8'd102,8'd105,
      8'd107,8'd109,8'd112,8'd114,8'd117,8'd119,8'd122,8'd124,8'd127,8'd130,8'd133,
      8'd136,8'd139,8'd142,8'd145,8'd148,8'd151,8'd155,8'd158,8'd162,8'd165,8'd169,
      8'd172,8'd176,8'd180,8'd184,8'd188,8'd192,8'd196,8'd201,8'd205,8'd210,8'd214,
      8'd219,8'd224,8'd229,8'd234,8'd239,8'd244,8'd250,8'd255
   };

   localparam logic [7:0] SQRT_TABLE [256] = '{
      8'd0,8'd15,8'd22,8'd27,8'd31,8'd35,8'd39,8'd42,8'd45,8'd47,8'd50,8'd52,8'd55,
      8'd57,8'd59,8'd61,8'd63,8'd65,8'd67,8'd69,8'd71,8'd73,8'd74,8'd76,8'd78,8'd79,
      8'd81,8'd82,8'd84,8'd85,8'd87,8'd88,8'd90,8'd91,8'd93,8'd94,8'd95,8'd97,8'd98,
      8'd99,8'd100,8'd102,8'd103,8'd104,8'd105,8'd107,8'd108,8'd109,8'd110,
      8'd111,8'd112,8'd114,8'd115,8'd116,8'd117,8'd118,8'd119,8'd120,8'd121,8'd122,
      8'd123,8'd124,8'd125,8'd126,8'd127,8'd128,8'd129,8'd130,
      8'd131,8'd132,8'd133,8'd134,8'd135,8'd136,8'd137,8'd138,8'd139,8'd140,8'd141,
      8'd141,8'd142,8'd143,8'd144,8'd145,8'd146,8'd147,8'd148,
      8'd148,8'd149,8'd150,8'd151,8'd152,8'd153,8'd153,8'd154,8'd155,8'd156,8'd157,
      8'd158,8'd158,8'd159,8'd160,8'd161,8'd162,8'd162,8'd163,
      8'd164,8'd165,8'd165,8'd166,8'd167,8'd168,8'd168,8'd169,8'd170,8'd171,8'd171,
      8'd172,8'd173,8'd174,8'd174,8'd175,8'd176,8'd177,8'd177,
      8'd178,8'd179,8'd179,8'd180,8'd181,8'd182,8'd182,8'd183,8'd184,8'd184,8'd185,
      8'd186,8'd186,8'd187,8'd188,8'd188,8'd189,8'd190,8'd190,
      8'd191,8'd192,8'd192,8'd193,8'd194,8'd194,8'd195,8'd196,8'd196,8'd197,8'd198,
      8'd198,8'd199,8'd200,8'd200,8'd201,8'd201,8'd202,8'd203,
      8'd203,8'd204,8'd205,8'd205,8'd206,8'd206,8'd207,8'd208,8'd208,8'd209,8'd210,
      8'd210,8'd211,8'd211,8'd212,8'd213,8'd213,8'd214,8'd214,
      8'd215,8'd216,8'd216,8'd217,8'd217,8'd218,8'd218,8'd219,8'd220,8'd220,8'd221,
      8'd221,8'd222,8'd222,8'd223,8'd224,8'd224,8'd225,8'd225,
      8'd226,8'd226,8'd227,8'd228,8'd228,8'd229,8'd229,8'd230,8'd230,8'd231,8'd231,
      8'd232,8'd233,8'd233,8'd234,8'd234,8'd235,8'd235,8'd236,
      8'd236,8'd237,8'd237,8'd238,8'd238,8'd239,8'd240,8'd240,8'd241,8'd241,8'd242,
      8'd242,8'd243,8'd243,8'd244,8'd244,8'd245,8'd245,8'd246,
      8'd246,8'd247,8'd247,8'd248,8'd248,8'd249,8'd249,8'd250,8'd250,8'd251,8'd251,
      8'd252,8'd252,8'd253,8'd253,8'd254,8'd255
   };

   // Exponential brightness curve indexed by the ramp's high byte
   function automatic logic [7:0] exp_lut(input logic [7:0] idx);
      return EXP_TABLE[idx];
   endfunction

   // Gamma weight of one brightness level
   function automatic logic [7:0] sqrt_lut(input logic [7:0] idx);
      return SQRT_TABLE[idx];
   endfunction

endpackage
`default_nettype wire

/* hdl/arll_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
module arll_filter
   import arll_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire logic signed [15:0] sample,
   input  wire logic [3:0]         dc_shift,
   input  wire logic [3:0]         bass_shift,
   output logic [15:0]             bass_mag,
   output logic [15:0]             treble_mag
);

   logic signed [15:0] dc_ff, dc_in;
   logic signed [15:0] smooth_ff, smooth_in;
   logic signed [15:0] bass_ff, bass_in;
   logic signed [15:0] no_dc;
   logic signed [15:0] smooth_sum;
   logic signed [15:0] resid;
   logic [15:0]        bass_mag_ff, treble_mag_ff;

   // Remove DC, average with the previous value, split off the low band
   always_comb begin
      no_dc      = sample - dc_ff;
      dc_in      = dc_ff + (no_dc >>> dc_shift);
      smooth_sum = smooth_ff + no_dc;
      smooth_in  = smooth_sum >>> 1;
      resid      = smooth_in - bass_ff;
      bass_in    = bass_ff + (resid >>> bass_shift);
   end

   // Filter state advances once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff     <= '0;
         smooth_ff <= '0;
         bass_ff   <= '0;
      end else if (load) begin
         dc_ff     <= dc_in;
         smooth_ff <= smooth_in;
         bass_ff   <= bass_in;
      end
   end

   // Register magnitudes; the most negative value wraps to itself
   always_ff @(posedge clock) begin
      if (load) begin
         bass_mag_ff   <= bass_in[15] ? 16'(16'd0 - bass_in) : bass_in;
         treble_mag_ff <= resid[15] ? 16'(16'd0 - resid) : resid;
      end
   end

   assign bass_mag   = bass_mag_ff;
   assign treble_mag = treble_mag_ff;

endmodule
`default_nettype wire

/* hdl/arll_chan.sv */
`timescale 1ns / 1ps
`default_nettype none
module arll_chan
   import arll_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              period_end,
   input  wire logic [15:0]       mag,
   input  wire logic [14:0]       thresh_init,
   input  wire arll_chan_cfg_type cfg,
   output logic [7:0]             level
);

   logic signed [15:0] thresh_ff, thresh_in;
   logic signed [15:0] up_one, up_val, down_one, down_val;
   logic signed [15:0] thresh_cur;
   logic [15:0]        ramp_ff, ramp_in;
   logic [15:0]        energy_ff, energy_in, energy_base;
   logic [7:0]         level_ff, level_in;
   logic               hit;

   // Adapt the threshold from the energy gathered over the last period
   always_comb begin
      up_one   = thresh_ff + 16'sd1;
      up_val   = up_one + (up_one >>> 10);
      down_one = thresh_ff - (thresh_ff >>> 10);
      down_val = down_one - 16'sd1;
      thresh_in = thresh_ff;
      if (energy_ff > ENERGY_LIMIT) begin
         if (thresh_ff < THRESH_CEIL) begin
            thresh_in = up_val;
         end
      end else if (thresh_ff > $signed({1'b0, cfg.floor_v})) begin
         thresh_in = down_val;
      end
      thresh_cur = period_end ? thresh_in : thresh_ff;
   end

   // Step the ramp up on a hit, down otherwise, hold at the ends
   always_comb begin
      hit     = $signed(mag) > thresh_cur;
      ramp_in = ramp_ff;
      if (hit) begin
         if (ramp_ff <= 16'(16'hFFFF - cfg.rise)) begin
            ramp_in = 16'(ramp_ff + cfg.rise);
         end
      end else if (ramp_ff >= cfg.fall) begin
         ramp_in = 16'(ramp_ff - cfg.fall);
      end
   end

   // Look up brightness and accumulate its gamma weight
   always_comb begin
      level_in    = exp_lut(ramp_in[15:8]);
      energy_base = period_end ? 16'd0 : energy_ff;
      energy_in   = 16'(energy_base + {8'd0, sqrt_lut(level_in)});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= $signed({1'b0, thresh_init});
         ramp_ff   <= '0;
         energy_ff <= '0;
      end else if (advance) begin
         thresh_ff <= thresh_cur;
         ramp_ff   <= ramp_in;
         energy_ff <= energy_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule
`default_nettype wire

/* hdl/audio_reactive_led_level.sv */
// Audio reactive LED level.
// Input channel (req_): one signed 16-bit audio sample per transaction.
// Result channel (rsp_): one transaction per sample with the treble and bass
// LED brightness levels, in input order.
// Configuration (csr_): a write port for the eight filter and ramp settings;
// write it only while no transaction is in flight.
// Path: an accepted sample loads the filter registers, then the channel result
// registers, which drive the rsp_ levels together with the rsp_valid register.
// Throughput: one sample per clock cycle while no stalled result is held; the
// filter, threshold, ramp and energy loops each close within one stage.
// Reset: clears the pipeline, filter state, ramps and energies, loads the
// thresholds with their floor defaults and the settings with their defaults.
// Stall: while rsp_stall holds a waiting result, the whole pipeline freezes
// and req_stall is raised in the same cycle; no state advances.
`timescale 1ns / 1ps
`default_nettype none
`include "audio_reactive_led_level_assert.svh"
module audio_reactive_led_level
   import arll_pkg::*;
#(
   parameter int unsigned ADAPT_PERIOD = ADAPT_PERIOD_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [15:0]    req_sample,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_treble_level,
   output logic [7:0]                 rsp_bass_level,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [15:0]           csr_wdata
);

   localparam int unsigned CNT_W = $clog2(ADAPT_PERIOD);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ADAPT_PERIOD - 1);

   logic [3:0]        dc_shift_ff, bass_shift_ff;
   arll_chan_cfg_type treble_cfg_ff, bass_cfg_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              flow;
   logic              take;
   logic              adv2;
   logic              period_end;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]       bass_mag, treble_mag;

   // Settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dc_shift_ff           <= DC_SHIFT_RST;
         bass_shift_ff         <= BASS_SHIFT_RST;
         treble_cfg_ff.rise    <= TREBLE_RISE_RST;
         treble_cfg_ff.fall    <= TREBLE_FALL_RST;
         treble_cfg_ff.floor_v <= TREBLE_FLOOR_RST;
         bass_cfg_ff.rise      <= BASS_RISE_RST;
         bass_cfg_ff.fall      <= BASS_FALL_RST;
         bass_cfg_ff.floor_v   <= BASS_FLOOR_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_DC_SHIFT:     dc_shift_ff           <= csr_wdata[3:0];
            REG_BASS_SHIFT:   bass_shift_ff         <= csr_wdata[3:0];
            REG_TREBLE_RISE:  treble_cfg_ff.rise    <= csr_wdata;
            REG_TREBLE_FALL:  treble_cfg_ff.fall    <= csr_wdata;
            REG_BASS_RISE:    bass_cfg_ff.rise      <= csr_wdata;
            REG_BASS_FALL:    bass_cfg_ff.fall      <= csr_wdata;
            REG_TREBLE_FLOOR: treble_cfg_ff.floor_v <= csr_wdata[14:0];
            REG_BASS_FLOOR:   bass_cfg_ff.floor_v   <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline control: advance unless a held result is stalled
   always_comb begin
      flow         = !rsp_valid_ff || !rsp_stall;
      take         = req_valid && flow;
      adv2         = s1_valid_ff && flow;
      s1_valid_in  = flow ? req_valid : s1_valid_ff;
      rsp_valid_in = flow ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Adaptation period counter, wraps to zero at the period end
   always_comb begin
      period_end = (cnt_ff == CNT_LAST);
      cnt_in     = period_end ? '0 : CNT_W'(cnt_ff + CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (adv2) begin
         cnt_ff <= cnt_in;
      end
   end

   arll_filter u_filter (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .sample     (req_sample),
      .dc_shift   (dc_shift_ff),
      .bass_shift (bass_shift_ff),
      .bass_mag   (bass_mag),
      .treble_mag (treble_mag)
   );

   arll_chan u_treble (
      .clock       (clock),
      .reset       (reset),
      .advance     (adv2),
      .period_end  (period_end),
      .mag         (treble_mag),
      .thresh_init (TREBLE_FLOOR_RST),
      .cfg         (treble_cfg_ff),
      .level       (rsp_treble_level)
   );

   arll_chan u_bass (
      .clock       (clock),
      .reset       (reset),
      .advance     (adv2),
      .period_end  (period_end),
      .mag         (bass_mag),
      .thresh_init (BASS_FLOOR_RST),
      .cfg         (bass_cfg_ff),
      .level       (rsp_bass_level)
   );

   assign req_stall = !flow;
   assign rsp_valid = rsp_valid_ff;

   // Checks
   `ARLL_ASSERT_NEXT(a_take_fills_s1, req_valid && !req_stall, s1_valid_ff)
   `ARLL_ASSERT_NEXT(a_s1_moves_out, s1_valid_ff && !req_stall, rsp_valid)
   `ARLL_ASSERT_SAME(a_stall_backs_up, rsp_valid && rsp_stall, req_stall)
   `ARLL_ASSERT_NEXT(a_counter_wraps, adv2 && (cnt_ff == CNT_LAST), cnt_ff == '0)

endmodule
`default_nettype wire

/* verif/tb_audio_reactive_led_level.sv */
`timescale 1ns / 1ps
module tb_audio_reactive_led_level;
   import arll_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 6;
   localparam int SAMPLES_PER_RUN = 85;
   localparam int SETTLE_CYCLES   = 4;

   typedef enum int {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_mode_type;

   typedef struct packed {
      logic [7:0] treble;
      logic [7:0] bass;
   } led_levels_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic signed [15:0]    req_sample  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [7:0]            rsp_treble_level;
   logic [7:0]            rsp_bass_level;
   logic                  csr_we      = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr    = '0;
   logic [15:0]           csr_wdata   = '0;

   logic signed [15:0] pending_samples[$];
   led_levels_type     expected_levels[$];
   pace_mode_type      pace_mode = PACE_FULL;
   int                 error_count = 0;
   int                 cycle_count = 0;

   // Shadow copy of the settings
   logic [3:0]  cfg_dc_shift, cfg_bass_shift;
   logic [15:0] cfg_treble_rise, cfg_treble_fall, cfg_bass_rise, cfg_bass_fall;
   logic [14:0] cfg_treble_floor, cfg_bass_floor;

   // Shadow copy of the filter, threshold and ramp state
   logic [15:0] dc_level, smooth_level, bass_level_est;
   int          period_count;
   logic [15:0] treble_thr, bass_thr;
   logic [15:0] treble_ramp_q, bass_ramp_q;
   logic [15:0] treble_energy_q, bass_energy_q;

   audio_reactive_led_level u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_treble_level (rsp_treble_level),
      .rsp_bass_level   (rsp_bass_level),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] asr16(input logic [15:0] v, input logic [3:0] sh);
      return $signed(v) >>> sh;
   endfunction

   function automatic logic [15:0] magnitude16(input logic [15:0] v);
      return v[15] ? 16'd0 - v : v;
   endfunction

   // Raise on a loud period, decay toward the floor on a quiet one
   function automatic logic [15:0] adapt_threshold(input logic [15:0] thr,
                                                   input logic [15:0] energy,
                                                   input logic [14:0] floor_v);
      logic [15:0] t;
      t = thr;
      if (energy > ENERGY_LIMIT) begin
         if ($signed(t) < THRESH_CEIL) begin
            t = t + 16'd1;
            t = t + asr16(t, 4'd10);
         end
      end else if ($signed(t) > $signed({1'b0, floor_v})) begin
         t = t - asr16(t, 4'd10);
         t = t - 16'd1;
      end
      return t;
   endfunction

   // Rise on a hit, fall otherwise; skip any step that would wrap
   function automatic logic [15:0] step_ramp(input logic [15:0] r, input logic hit,
                                             input logic [15:0] up, input logic [15:0] down);
      if (hit) begin
         if (r <= 16'hFFFF - up) r = r + up;
      end else if (r >= down) begin
         r = r - down;
      end
      return r;
   endfunction

   task automatic reset_model();
      cfg_dc_shift     = DC_SHIFT_RST;
      cfg_bass_shift   = BASS_SHIFT_RST;
      cfg_treble_rise  = TREBLE_RISE_RST;
      cfg_treble_fall  = TREBLE_FALL_RST;
      cfg_bass_rise    = BASS_RISE_RST;
      cfg_bass_fall    = BASS_FALL_RST;
      cfg_treble_floor = TREBLE_FLOOR_RST;
      cfg_bass_floor   = BASS_FLOOR_RST;
      dc_level         = '0;
      smooth_level     = '0;
      bass_level_est   = '0;
      period_count     = 0;
      treble_thr       = {1'b0, TREBLE_FLOOR_RST};
      bass_thr         = {1'b0, BASS_FLOOR_RST};
      treble_ramp_q    = '0;
      bass_ramp_q      = '0;
      treble_energy_q  = '0;
      bass_energy_q    = '0;
   endtask

   // Advance the shadow state by one sample and queue the LED levels it gives
   task automatic predict_led_levels(input logic [15:0] x);
      logic [15:0] s, resid;
      led_levels_type lv;
      s              = x - dc_level;
      dc_level       = dc_level + asr16(s, cfg_dc_shift);
      smooth_level   = asr16(smooth_level + s, 4'd1);
      resid          = smooth_level - bass_level_est;
      bass_level_est = bass_level_est + asr16(resid, cfg_bass_shift);

      period_count = (period_count + 1) % ADAPT_PERIOD_DEF;
      if (period_count == 0) begin
         treble_thr      = adapt_threshold(treble_thr, treble_energy_q, cfg_treble_floor);
         bass_thr        = adapt_threshold(bass_thr, bass_energy_q, cfg_bass_floor);
         treble_energy_q = '0;
         bass_energy_q   = '0;
      end

      bass_ramp_q   = step_ramp(bass_ramp_q,
                                $signed(magnitude16(bass_level_est)) > $signed(bass_thr),
                                cfg_bass_rise, cfg_bass_fall);
      treble_ramp_q = step_ramp(treble_ramp_q,
                                $signed(magnitude16(resid)) > $signed(treble_thr),
                                cfg_treble_rise, cfg_treble_fall);

      lv.treble       = EXP_TABLE[treble_ramp_q[15:8]];
      lv.bass         = EXP_TABLE[bass_ramp_q[15:8]];
      treble_energy_q = treble_energy_q + {8'd0, SQRT_TABLE[lv.treble]};
      bass_energy_q   = bass_energy_q + {8'd0, SQRT_TABLE[lv.bass]};
      expected_levels.push_back(lv);
   endtask

   function automatic logic sender_pause();
      case (pace_mode)
         PACE_SENDER: return $urandom_range(99, 0) < 64;
         PACE_BOTH:   return $urandom_range(99, 0) < 12;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_pause();
      case (pace_mode)
         PACE_RECEIVER: return $urandom_range(99, 0) < 64;
         PACE_BOTH:     return $urandom_range(99, 0) < 12;
         default:       return 1'b0;
      endcase
   endfunction

   // Sample driver: predict on each accepted transaction, then load the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_led_levels(req_sample);
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 && !sender_pause()) begin
               req_valid  <= 1'b1;
               req_sample <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Level monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      led_levels_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $error("unexpected result: treble_level %0d bass_level %0d",
                      rsp_treble_level, rsp_bass_level);
               error_count++;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_treble_level !== want.treble) begin
                  $error("treble_level mismatch: expected %0d, actual %0d",
                         want.treble, rsp_treble_level);
                  error_count++;
               end
               if (rsp_bass_level !== want.bass) begin
                  $error("bass_level mismatch: expected %0d, actual %0d",
                         want.bass, rsp_bass_level);
                  error_count++;
               end
            end
         end
         rsp_stall <= receiver_pause();
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         REG_DC_SHIFT:     cfg_dc_shift     = value[3:0];
         REG_BASS_SHIFT:   cfg_bass_shift   = value[3:0];
         REG_TREBLE_RISE:  cfg_treble_rise  = value;
         REG_TREBLE_FALL:  cfg_treble_fall  = value;
         REG_BASS_RISE:    cfg_bass_rise    = value;
         REG_BASS_FALL:    cfg_bass_fall    = value;
         REG_TREBLE_FLOOR: cfg_treble_floor = value[14:0];
         REG_BASS_FLOOR:   cfg_bass_floor   = value[14:0];
         default: ;
      endcase
   endtask

   task automatic program_settings(input logic [3:0] dc_sh, input logic [3:0] bass_sh,
                                   input logic [15:0] t_rise, input logic [15:0] t_fall,
                                   input logic [15:0] b_rise, input logic [15:0] b_fall,
                                   input logic [14:0] t_floor, input logic [14:0] b_floor);
      write_reg(REG_DC_SHIFT, {12'd0, dc_sh});
      write_reg(REG_BASS_SHIFT, {12'd0, bass_sh});
      write_reg(REG_TREBLE_RISE, t_rise);
      write_reg(REG_TREBLE_FALL, t_fall);
      write_reg(REG_BASS_RISE, b_rise);
      write_reg(REG_BASS_FALL, b_fall);
      write_reg(REG_TREBLE_FLOOR, {1'b0, t_floor});
      write_reg(REG_BASS_FLOOR, {1'b0, b_floor});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every sample is taken and every result has come back
   task automatic wait_for_drain();
      while (pending_samples.size() != 0 || req_valid || expected_levels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Audio-like bursts: quiet hiss, bass square waves, treble toggles, full-scale noise
   task automatic queue_random_samples(input int count);
      int left, burst, kind, amp, period, k, iv;
      left = count;
      while (left > 0) begin
         burst  = $urandom_range(64, 16);
         if (burst > left) burst = left;
         kind   = $urandom_range(3, 0);
         amp    = $urandom_range(32767, 1);
         period = $urandom_range(32, 2);
         for (k = 0; k < burst; k++) begin
            case (kind)
               0:       iv = $urandom_range(256, 0) - 128;
               1:       iv = ((k / period) % 2) ? amp : -amp;
               2:       iv = (k % 2) ? amp : -amp;
               default: iv = $urandom_range(65535, 0) - 32768;
            endcase
            pending_samples.push_back(16'(iv));
         end
         left -= burst;
      end
   endtask

   initial begin
      int ph;
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, bit patterns, full-swing toggles, silence
      pace_mode = PACE_FULL;
      pending_samples.push_back(16'sd0);
      pending_samples.push_back(16'sd32767);
      pending_samples.push_back(-16'sd32768);
      pending_samples.push_back(-16'sd1);
      pending_samples.push_back(16'sd1);
      pending_samples.push_back(16'sh5555);
      pending_samples.push_back(16'shAAAA);
      for (int k = 0; k < 10; k++)
         pending_samples.push_back((k % 2) ? -16'sd32768 : 16'sd32767);
      for (int k = 0; k < 5; k++)
         pending_samples.push_back(16'sd0);
      wait_for_drain();

      // Random phases, each with its own settings and pacing
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin
               pace_mode = PACE_SENDER;
               program_settings(4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)),
                                16'($urandom_range(65535, 0)),
                                16'($urandom_range(65535, 0)),
                                16'($urandom_range(65535, 0)),
                                16'($urandom_range(65535, 0)),
                                15'($urandom_range(32000, 0)),
                                15'($urandom_range(32000, 0)));
            end
            1: begin
               pace_mode = PACE_BOTH;
               program_settings(4'd0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd0);
            end
            2: begin
               pace_mode = PACE_RECEIVER;
               program_settings(4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                15'd32000, 15'd32000);
            end
            3: begin
               // fast ramps that pin at the top, slow fall, zero floors
               pace_mode = PACE_FULL;
               program_settings(4'd0, 4'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 15'd0, 15'd0);
            end
            4: begin
               pace_mode = PACE_SENDER;
               program_settings(4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)),
                                16'($urandom_range(8000, 0)), 16'($urandom_range(2000, 0)),
                                16'($urandom_range(8000, 0)), 16'($urandom_range(2000, 0)),
                                15'($urandom_range(500, 0)), 15'($urandom_range(500, 0)));
            end
            default: begin
               pace_mode = PACE_BOTH;
               program_settings(DC_SHIFT_RST, BASS_SHIFT_RST, TREBLE_RISE_RST,
                                TREBLE_FALL_RST, BASS_RISE_RST, BASS_FALL_RST,
                                TREBLE_FLOOR_RST, BASS_FLOOR_RST);
            end
         endcase
         queue_random_samples(SAMPLES_PER_RUN);
         wait_for_drain();
      end

      if (error_count == 0 && expected_levels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/arll_pkg.sv
hdl/arll_filter.sv
hdl/arll_chan.sv
hdl/audio_reactive_led_level.sv
verif/tb_audio_reactive_led_level.sv
